// ----- rtl/resol_pkg.sv -----
// ----------------------------------------------------------------------------
// resol_pkg - shared types and constants for the ring entry store
// Ring depth, pointer widths, transaction payloads and the controller to
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package resol_pkg;

    // Ring geometry
    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths fixed by the transaction format
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFS_W    = 24;
    localparam int IDX_W    = 4;

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // Input transaction
    typedef struct packed {
        logic                opcode;
        logic [HANDLE_W-1:0] new_handle;
        logic [SIZE_W-1:0]   new_size;
        logic [OFS_W-1:0]    query_offset;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic                evicted_valid;
        logic [HANDLE_W-1:0] evicted_handle;
        logic                found;
        logic [IDX_W-1:0]    found_index;
        logic [HANDLE_W-1:0] found_handle;
        logic [SIZE_W-1:0]   found_size;
        logic [SIZE_W-1:0]   offset_in_entry;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming transaction, prime the walk
        logic add;    // store the entry, evict when full, write the result
        logic step;   // examine one slot of the walk
        logic last;   // this step examines the final slot
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;    // the slot under examination holds the offset
    } t_sts;

    // Advance a ring pointer with wrap
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/ring_entry_store_offset_lookup_top.sv -----
// ----------------------------------------------------------------------------
// ring_entry_store_offset_lookup_top - overwriting ring with offset lookup
// Stores handle and size entries in a ring and finds the entry holding a
// byte offset into all entries placed end to end.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a transaction on i_cmd and raise start; it is taken at a clock edge
//   with start high and busy low. busy stays high while it is processed.
//   An add goes from acceptance through the add state to the result strobe. A find walks
//   the ring from the oldest slot, one slot per cycle through a single
//   compare and subtract, and stops at the slot holding the offset or at the last slot.
//   Each transaction gives exactly one result on o_res, valid for the one
//   cycle that o_strobe is high; the receiver cannot stall it. busy drops
//   in the strobe cycle, so the next transaction may be taken alongside it.
//   Reset (synchronous, active low) empties the ring: pointers and full
//   flag clear and every slot reads as size zero until written.
// ----------------------------------------------------------------------------
module ring_entry_store_offset_lookup_top
    import resol_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_out o_res
);

    t_cmd cmd;
    t_sts sts;

    // Sequence the transaction
    resol_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_cmd.opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // Stores, pointers and result register
    resol_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_cmd),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_strobe_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobed while still busy");

    a_result_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_res.evicted_valid && o_res.found))
        else $error("result reports both an eviction and a find");
`endif

endmodule

// ----- rtl/resol_ctrl.sv -----
// ----------------------------------------------------------------------------
// resol_ctrl - sequencing controller for the ring entry store
// Accepts a transaction, runs an add step or a slot-by-slot walk, and
// raises the result strobe for one cycle at the end.
// ----------------------------------------------------------------------------
module resol_ctrl
    import resol_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_opcode,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_strobe
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_WALK
    } t_state;

    t_state           r_state, n_state;
    logic             r_busy, n_busy;
    logic             r_strobe, n_strobe;
    logic [PTR_W-1:0] r_cnt, n_cnt;

    // Decode commands from the current state
    always_comb begin
        o_cmd.load = i_start && !r_busy;
        o_cmd.add  = (r_state == S_ADD);
        o_cmd.step = (r_state == S_WALK);
        o_cmd.last = (r_cnt == PTR_W'(DEPTH - 1));
    end

    // Next state and registered outputs
    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        n_cnt    = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_busy  = 1'b1;
                    n_cnt   = '0;
                    n_state = (i_opcode == OP_FIND) ? S_WALK : S_ADD;
                end
            end
            S_ADD: begin
                n_busy   = 1'b0;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_WALK: begin
                if (i_sts.hit || o_cmd.last) begin
                    n_busy   = 1'b0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cnt = r_cnt + PTR_W'(1);
                end
            end
            default: begin
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

// ----- rtl/resol_dp.sv -----
// ----------------------------------------------------------------------------
// resol_dp - datapath of the ring entry store
// Entry stores with per-slot valid bits, ring pointers, the walk
// registers and the result register.
// ----------------------------------------------------------------------------
module resol_dp
    import resol_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_res
);

    // Entry stores; a slot not yet written reads as size zero
    logic [HANDLE_W-1:0] r_handle [DEPTH];
    logic [SIZE_W-1:0]   r_size   [DEPTH];
    logic [DEPTH-1:0]    r_valid;

    // Ring pointers
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic                r_full, n_full;

    // Captured transaction and walk state
    t_in                 r_in;
    logic [PTR_W-1:0]    r_pos;
    logic [OFS_W-1:0]    r_rem;
    t_out                r_res, n_res;

    logic [PTR_W-1:0]    rd_addr;
    logic [HANDLE_W-1:0] rd_handle;
    logic [SIZE_W-1:0]   rd_size;
    logic [OFS_W-1:0]    rd_size_ext;
    logic                hit;
    logic [31:0]         pos_wide;

    // Select the slot to read: oldest entry on add, walk position on find
    always_comb begin
        rd_addr     = i_cmd.add ? r_rd_ptr : r_pos;
        rd_handle   = r_handle[rd_addr];
        rd_size     = r_valid[rd_addr] ? r_size[rd_addr] : '0;
        rd_size_ext = OFS_W'(rd_size);
        hit         = (r_rem < rd_size_ext);
        pos_wide    = 32'(r_pos);
    end

    assign o_sts.hit = hit && i_cmd.step;

    // Pointer and full flag update on add
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_full   = r_full;
        if (i_cmd.add) begin
            n_wr_ptr = ptr_next(r_wr_ptr);
            if (r_full) begin
                n_rd_ptr = ptr_next(r_rd_ptr);
            end else if (ptr_next(r_wr_ptr) == r_rd_ptr) begin
                n_full = 1'b1;
            end
        end
    end

    // Hold control state: pointers, full flag, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_full   <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_full   <= n_full;
            if (i_cmd.add) begin
                r_valid[r_wr_ptr] <= 1'b1;
            end
        end
    end

    // Write the entry stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_handle[r_wr_ptr] <= r_in.new_handle;
            r_size[r_wr_ptr]   <= r_in.new_size;
        end
    end

    // Form the next result: eviction on add, located slot or none on find
    always_comb begin
        n_res = r_res;
        if (i_cmd.add) begin
            n_res                = '0;
            n_res.evicted_valid  = r_full;
            n_res.evicted_handle = r_full ? rd_handle : '0;
        end else if (i_cmd.step && hit) begin
            n_res                 = '0;
            n_res.found           = 1'b1;
            n_res.found_index     = pos_wide[IDX_W-1:0];
            n_res.found_handle    = rd_handle;
            n_res.found_size      = rd_size;
            n_res.offset_in_entry = r_rem[SIZE_W-1:0];
        end else if (i_cmd.step && i_cmd.last) begin
            n_res = '0;
        end
    end

    // Capture the transaction, advance the walk, hold the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_in;
            r_pos <= r_rd_ptr;
            r_rem <= i_in.query_offset;
        end else if (i_cmd.step && !hit) begin
            r_pos <= ptr_next(r_pos);
            r_rem <= r_rem - rd_size_ext;
        end

        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- tb/sv/ring_entry_store_offset_lookup_top_test.sv -----
// ----------------------------------------------------------------------------
// ring_entry_store_offset_lookup_top_test - self-checking bench for the ring store
// Runs a short table of add and find transactions against a freshly reset
// ring, then a long stream of random ones in bursts with random gaps. Each
// accepted transaction is predicted by a behavioural copy of the ring, and
// every strobed result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module ring_entry_store_offset_lookup_top_test;
    import resol_pkg::*;

    localparam int N_RANDOM  = 1300;
    localparam int DRAIN_CYC = DEPTH + 8;

    // One row of the directed table
    typedef struct {
        t_in  cmd;
        bit   fixed;    // result written into the row, not predicted
        t_out want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_cmd;
    logic busy;
    logic o_strobe;
    t_out o_res;

    // Behavioural copy of the ring
    logic [HANDLE_W-1:0] ring_handle [DEPTH];
    logic [SIZE_W-1:0]   ring_size   [DEPTH];
    logic [PTR_W-1:0]    ring_wr;
    logic [PTR_W-1:0]    ring_rd;
    logic                ring_full;

    t_out pending_results [$];
    int   mismatch_count = 0;

    ring_entry_store_offset_lookup_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always #2 i_clk = ~i_clk;

    // Step a slot number round the ring
    function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % DEPTH);
    endfunction

    function automatic t_in add_cmd(input logic [HANDLE_W-1:0] h,
                                    input logic [SIZE_W-1:0] s);
        t_in c;
        c            = '0;
        c.opcode     = OP_ADD;
        c.new_handle = h;
        c.new_size   = s;
        return c;
    endfunction

    function automatic t_in find_cmd(input logic [OFS_W-1:0] ofs);
        t_in c;
        c              = '0;
        c.opcode       = OP_FIND;
        c.query_offset = ofs;
        return c;
    endfunction

    function automatic t_out located(input logic [IDX_W-1:0] idx,
                                     input logic [HANDLE_W-1:0] h,
                                     input logic [SIZE_W-1:0] s,
                                     input logic [SIZE_W-1:0] ofs);
        t_out r;
        r                 = '0;
        r.found           = 1'b1;
        r.found_index     = idx;
        r.found_handle    = h;
        r.found_size      = s;
        r.offset_in_entry = ofs;
        return r;
    endfunction

    // Work out the result of one transaction and advance the ring copy
    function automatic t_out predict_ring_result(input t_in cmd);
        t_out             res;
        logic [OFS_W-1:0] rem;
        logic [PTR_W-1:0] pos;
        bit               hit;
        res = '0;
        if (cmd.opcode == OP_ADD) begin
            // evict the oldest entry of a full ring first
            if (ring_full) begin
                res.evicted_valid  = 1'b1;
                res.evicted_handle = ring_handle[ring_rd];
                ring_rd            = slot_after(ring_rd);
            end
            ring_handle[ring_wr] = cmd.new_handle;
            ring_size[ring_wr]   = cmd.new_size;
            ring_wr              = slot_after(ring_wr);
            if (!ring_full && ring_wr == ring_rd) begin
                ring_full = 1'b1;
            end
        end else begin
            // walk every slot from the oldest, skipping empty ones
            rem = cmd.query_offset;
            pos = ring_rd;
            hit = 1'b0;
            for (int n = 0; n < DEPTH && !hit; n++) begin
                if (rem < OFS_W'(ring_size[pos])) begin
                    hit = 1'b1;
                    res = located(IDX_W'(pos), ring_handle[pos], ring_size[pos],
                                  SIZE_W'(rem));
                end else begin
                    rem = rem - OFS_W'(ring_size[pos]);
                    pos = slot_after(pos);
                end
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    // Offer one transaction and hold it until taken, then log its result
    task automatic issue(input t_in cmd, input bit fixed, input t_out want);
        t_out pred;
        i_cmd <= cmd;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pred = predict_ring_result(cmd);
        pending_results.push_back(fixed ? want : pred);
    endtask

    // Compare each strobed result with the oldest outstanding one
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with no transaction outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("evicted_valid",   o_res.evicted_valid,   want.evicted_valid);
                check_field("evicted_handle",  o_res.evicted_handle,  want.evicted_handle);
                check_field("found",           o_res.found,           want.found);
                check_field("found_index",     o_res.found_index,     want.found_index);
                check_field("found_handle",    o_res.found_handle,    want.found_handle);
                check_field("found_size",      o_res.found_size,      want.found_size);
                check_field("offset_in_entry", o_res.offset_in_entry, want.offset_in_entry);
            end
        end
    end

    // Stimulus
    initial begin
        t_dir_row         dir_table [$];
        t_out             evict_first;
        t_in              cmd;
        int               issued;
        int               burst;
        int               gap;
        int               total;
        int               span;
        logic [PTR_W-1:0] p;

        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        foreach (ring_handle[i]) begin
            ring_handle[i] = '0;
            ring_size[i]   = '0;
        end
        ring_wr   = '0;
        ring_rd   = '0;
        ring_full = 1'b0;

        // Directed table: empty ring, extremes, zero-size skip, fill and evict
        evict_first                = '0;
        evict_first.evicted_valid  = 1'b1;
        evict_first.evicted_handle = '1;
        dir_table.push_back('{find_cmd('0), 1'b1, '0});
        dir_table.push_back('{find_cmd('1), 1'b1, '0});
        dir_table.push_back('{add_cmd('1, '1), 1'b1, '0});
        dir_table.push_back('{add_cmd('0, '0), 1'b1, '0});
        dir_table.push_back('{add_cmd(32'h1234_5678, 16'd1), 1'b1, '0});
        dir_table.push_back('{find_cmd('0), 1'b1, located(4'd0, '1, '1, 16'h0000)});
        dir_table.push_back('{find_cmd(24'h00_FFFE), 1'b1,
                              located(4'd0, '1, '1, 16'hFFFE)});
        dir_table.push_back('{find_cmd(24'h00_FFFF), 1'b1,
                              located(4'd2, 32'h1234_5678, 16'd1, 16'h0000)});
        dir_table.push_back('{find_cmd(24'h01_0000), 1'b1, '0});
        for (int k = 0; k < DEPTH - 3; k++) begin
            dir_table.push_back('{add_cmd(32'hA5A5_0000 | k, SIZE_W'(3 * k + 2)),
                                  1'b0, '0});
        end
        dir_table.push_back('{add_cmd(32'h5A5A_5A5A, 16'h0100), 1'b1, evict_first});
        dir_table.push_back('{find_cmd('0), 1'b1,
                              located(4'd2, 32'h1234_5678, 16'd1, 16'h0000)});
        dir_table.push_back('{find_cmd('1), 1'b1, '0});

        // Hold reset, then release
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table back to back
        foreach (dir_table[r]) begin
            issue(dir_table[r].cmd, dir_table[r].fixed, dir_table[r].want);
        end

        // Random transactions in bursts
        issued = 0;
        while (issued < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && issued < N_RANDOM; b++) begin
                cmd.new_handle   = HANDLE_W'($urandom);
                cmd.new_size     = SIZE_W'($urandom);
                cmd.query_offset = OFS_W'($urandom);
                if ($urandom_range(99) < 45) begin
                    cmd.opcode = OP_ADD;
                    case ($urandom_range(9))
                        0: cmd.new_size = '0;
                        1: cmd.new_size = '1;
                        2, 3: ;
                        default: cmd.new_size = SIZE_W'($urandom_range(1, 300));
                    endcase
                    if ($urandom_range(19) == 0) begin
                        cmd.new_handle = $urandom_range(1) ? '1 : '0;
                    end
                end else begin
                    cmd.opcode = OP_FIND;
                    total      = 0;
                    foreach (ring_size[i]) total += ring_size[i];
                    case ($urandom_range(9))
                        // keep the raw offset, usually far past the end
                        0: ;
                        1: cmd.query_offset = OFS_W'(total);
                        2, 3: begin
                            // land on, or just short of, an entry boundary
                            span = 0;
                            p    = ring_rd;
                            repeat ($urandom_range(DEPTH - 1)) begin
                                span += ring_size[p];
                                p = slot_after(p);
                            end
                            cmd.query_offset = OFS_W'(span - int'($urandom_range(1)));
                        end
                        default: cmd.query_offset =
                            OFS_W'($urandom_range(total > 0 ? total - 1 : 0));
                    endcase
                end
                issue(cmd, 1'b0, '0);
                issued++;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        // Drain outstanding results, then allow for stray strobes
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
